// File: src/pcd_pkg.sv
// Shared types, codes and the CRC-32 byte update for the PNG chunk deframer.
package pcd_pkg;

    // Reflected CRC-32 polynomial and the all-ones init / final xor value.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Index of the last byte in a four-byte field.
    localparam logic [1:0] LAST_BYTE_IDX = 2'd3;

    // Field being received; the code is also the field tag on the output.
    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_TYPE   = 2'd1,
        PH_DATA   = 2'd2,
        PH_CRC    = 2'd3
    } pcd_phase_t;

    // Check result codes.
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_MATCH    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // One output word as held in the result register.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  field_kind;
        logic [31:0] chunk_length;
        logic [31:0] chunk_type;
        logic        chunk_last;
        logic [1:0]  crc_status;
        logic [31:0] crc_calc;
    } pcd_result_t;

    // Advance the CRC register over one byte, least significant bit first.
    function automatic logic [31:0] pcd_crc_byte(input logic [31:0] crc_in,
                                                 input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/pcd_stream_if.sv
// Valid/ready stream interfaces for the byte input and the tagged result output.
interface pcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface pcd_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  field_kind;
    logic [31:0] chunk_length;
    logic [31:0] chunk_type;
    logic        chunk_last;
    logic [1:0]  crc_status;
    logic [31:0] crc_calc;

    modport source (output valid, output out_byte, output field_kind, output chunk_length,
                    output chunk_type, output chunk_last, output crc_status,
                    output crc_calc, input ready);
    modport sink   (input valid, input out_byte, input field_kind, input chunk_length,
                    input chunk_type, input chunk_last, input crc_status,
                    input crc_calc, output ready);
endinterface

// File: src/png_chunk_deframer_crc_check.sv
// Top level of the PNG chunk deframer with CRC-32 check.
// An accepted input word reaches its result word through the input register, then the
// result register; the byte-wide CRC update sits between the two.
// Throughput: one byte per cycle while the result side does not stall; one result word per input word.
// Reset: rst_n clears both valid bits and returns the parser to the length field
// with the CRC register at all ones; no clearing pass is needed.
module png_chunk_deframer_crc_check (
    input  logic         clk,
    input  logic         rst_n,
    pcd_byte_if.sink     bytes,
    pcd_result_if.source results
);

    pcd_byte_if staged ();

    // Input register.
    pcd_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes),
        .staged (staged.source)
    );

    // Parser and result register.
    pcd_parse_stage u_parse_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .staged  (staged.sink),
        .results (results)
    );

endmodule

// File: src/pcd_in_stage.sv
// Input register stage: captures one byte and holds it until the parser takes it.
module pcd_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    pcd_byte_if.sink     bytes,
    pcd_byte_if.source   staged
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // The register takes a new word when empty or when its word moves on this cycle.
    assign bytes.ready = !valid_reg || staged.ready;
    assign load        = bytes.valid && bytes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (bytes.ready)
        begin
            valid_next = bytes.valid;
        end
    end

    // Valid bit with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= bytes.in_byte;
        end
    end

    assign staged.valid   = valid_reg;
    assign staged.in_byte = byte_reg;

endmodule

// File: src/pcd_parse_stage.sv
// Chunk parser: tracks the field, runs the CRC and loads the result register.
module pcd_parse_stage
    import pcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pcd_byte_if.sink     staged,
    pcd_result_if.source results
);

    pcd_phase_t  phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rx_crc_reg, rx_crc_next;
    logic        out_valid_reg, out_valid_next;
    pcd_result_t res_reg, res_next;

    logic [7:0]  b;
    logic [31:0] remain_dec;
    logic [31:0] rx_shifted;
    logic [31:0] crc_final;
    logic        take;

    // A word moves into the result register when that register is free or drains.
    assign staged.ready = !out_valid_reg || results.ready;
    assign take         = staged.valid && staged.ready;

    assign b          = staged.in_byte;
    assign remain_dec = remain_reg - 32'd1;
    assign rx_shifted = {rx_crc_reg[23:0], b};
    assign crc_final  = crc_reg ^ ALL_ONES;

    // Field tracking, CRC update and the result word for the staged byte.
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        length_next = length_reg;
        remain_next = remain_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;

        res_next.out_byte     = b;
        res_next.field_kind   = phase_reg;
        res_next.chunk_length = 32'd0;
        res_next.chunk_type   = 32'd0;
        res_next.chunk_last   = 1'b0;
        res_next.crc_status   = ST_NONE;
        res_next.crc_calc     = 32'd0;

        unique case (phase_reg)
            PH_LENGTH:
            begin
                length_next = {length_reg[23:0], b};
                if (idx_reg == LAST_BYTE_IDX)
                begin
                    remain_next = {length_reg[23:0], b};
                    idx_next    = 2'd0;
                    phase_next  = PH_TYPE;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            PH_TYPE:
            begin
                res_next.chunk_length = length_reg;
                type_next = type_reg | ({24'd0, b} << {idx_reg, 3'b000});
                crc_next  = pcd_crc_byte(crc_reg, b);
                if (idx_reg == LAST_BYTE_IDX)
                begin
                    idx_next   = 2'd0;
                    phase_next = (remain_reg == 32'd0) ? PH_CRC : PH_DATA;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            PH_DATA:
            begin
                res_next.chunk_length = length_reg;
                res_next.chunk_type   = type_reg;
                crc_next    = pcd_crc_byte(crc_reg, b);
                remain_next = remain_dec;
                if (remain_dec == 32'd0)
                begin
                    idx_next   = 2'd0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                res_next.chunk_length = length_reg;
                res_next.chunk_type   = type_reg;
                rx_crc_next = rx_shifted;
                if (idx_reg == LAST_BYTE_IDX)
                begin
                    res_next.crc_calc     = crc_final;
                    res_next.chunk_last   = 1'b1;
                    res_next.crc_status   = (crc_final == rx_shifted) ? ST_MATCH : ST_MISMATCH;
                    crc_next    = ALL_ONES;
                    type_next   = 32'd0;
                    rx_crc_next = 32'd0;
                    idx_next    = 2'd0;
                    phase_next  = PH_LENGTH;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            default:
            begin
                phase_next = PH_LENGTH;
            end
        endcase
    end

    // Output valid follows the handshake on both sides.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (staged.ready)
        begin
            out_valid_next = staged.valid;
        end
    end

    // Chunk state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LENGTH;
            idx_reg       <= 2'd0;
            length_reg    <= 32'd0;
            remain_reg    <= 32'd0;
            type_reg      <= 32'd0;
            crc_reg       <= ALL_ONES;
            rx_crc_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg  <= phase_next;
                idx_reg    <= idx_next;
                length_reg <= length_next;
                remain_reg <= remain_next;
                type_reg   <= type_next;
                crc_reg    <= crc_next;
                rx_crc_reg <= rx_crc_next;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.out_byte     = res_reg.out_byte;
    assign results.field_kind   = res_reg.field_kind;
    assign results.chunk_length = res_reg.chunk_length;
    assign results.chunk_type   = res_reg.chunk_type;
    assign results.chunk_last   = res_reg.chunk_last;
    assign results.crc_status   = res_reg.crc_status;
    assign results.crc_calc     = res_reg.crc_calc;

`ifndef SYNTHESIS
    // The data field is only entered with bytes left to count.
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (remain_reg != 32'd0 && idx_reg == 2'd0))
        else $error("data field entered with no bytes remaining");

    // A status is reported exactly on chunk end, and only in the crc field.
    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> ((results.chunk_last == (results.crc_status != ST_NONE)) &&
                           (!results.chunk_last || results.field_kind == PH_CRC)))
        else $error("crc status outside chunk end");

    // Length field words carry no chunk length or type.
    a_length_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.field_kind == PH_LENGTH) |->
            (results.chunk_length == 32'd0 && results.chunk_type == 32'd0))
        else $error("length field word carries stale chunk info");

    // After a chunk end is taken the parser restarts at the length field.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_CRC && idx_reg == LAST_BYTE_IDX) |=>
            (phase_reg == PH_LENGTH && crc_reg == ALL_ONES && type_reg == 32'd0))
        else $error("parser did not restart after chunk end");
`endif

endmodule
